// ===== sv/rhsv_pkg.sv =====
package rhsv_pkg;

  localparam int RGB_W      = 8;
  localparam int HUE_W      = 15;
  localparam int SAT_W      = 16;
  // quotient / low-dividend width of both long dividers
  localparam int DQ_W       = 16;
  localparam int DIV_STAGES = DQ_W;
  // width of 3840 * |num|, |num| <= 255
  localparam int HDIV_W     = 20;

  localparam int HUE_SIXTY  = 3840;   // 60 deg in 1/64 deg
  localparam int HUE_FULL   = 23040;  // 360 deg

  typedef logic [RGB_W-1:0] chan_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // per-pixel info that rides alongside the dividers
  typedef struct packed {
    chan_t   brightness;
    chan_t   delta;
    sector_t sector;
    logic    neg;
  } side_t;

  typedef struct packed {
    side_t side;
    chan_t abs_num;
  } front_t;

  // restoring divider state: partial remainder, dividend bits shifting out
  // at the top while quotient bits shift in at the bottom
  typedef struct packed {
    chan_t           rem;
    logic [DQ_W-1:0] dq;
    chan_t           divisor;
  } div_t;

  typedef struct packed {
    side_t side;
    div_t  sat;
    div_t  hue;
  } div_stage_t;

  typedef struct packed {
    side_t           side;
    logic [DQ_W-1:0] sat_q;
    logic [DQ_W-1:0] hue_q;
    logic            hue_inexact;
  } quot_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    chan_t            brightness;
  } hsv_t;

  // one quotient bit; requires rem < divisor on entry
  function automatic div_t div_step(div_t d);
    logic [RGB_W:0] trial;
    logic [RGB_W:0] diff;
    div_t           res;
    trial = {d.rem, d.dq[DQ_W-1]};
    diff  = trial - {1'b0, d.divisor};
    res   = d;
    if (trial >= {1'b0, d.divisor}) begin
      res.rem = diff[RGB_W-1:0];
      res.dq  = {d.dq[DQ_W-2:0], 1'b1};
    end else begin
      res.rem = trial[RGB_W-1:0];
      res.dq  = {d.dq[DQ_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [HUE_W-1:0] sector_base(sector_t s);
    logic [HUE_W-1:0] b;
    unique case (s)
      SEC_RED:   b = '0;
      SEC_GREEN: b = HUE_W'(2 * HUE_SIXTY);
      SEC_BLUE:  b = HUE_W'(4 * HUE_SIXTY);
      default:   b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/rhsv_pix_if.sv =====
interface rhsv_pix_if;
  logic                 valid;
  logic                 ready;
  logic [rhsv_pkg::RGB_W-1:0] red;
  logic [rhsv_pkg::RGB_W-1:0] green;
  logic [rhsv_pkg::RGB_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== sv/rhsv_hsv_if.sv =====
interface rhsv_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rhsv_pkg::HUE_W-1:0] hue;
  logic [rhsv_pkg::SAT_W-1:0] saturation;
  logic [rhsv_pkg::RGB_W-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== sv/rhsv_front.sv =====
module rhsv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  rhsv_pkg::chan_t   red,
  input  rhsv_pkg::chan_t   green,
  input  rhsv_pkg::chan_t   blue,
  output logic              valid_r,
  output rhsv_pkg::front_t  data_r
);
  import rhsv_pkg::*;

  sector_t        sector;
  chan_t          mx;
  chan_t          lo;
  chan_t          mn;
  logic [RGB_W:0] diff;
  logic [RGB_W:0] abs_full;
  front_t         data_nxt;

  // ties: red over green over blue
  always_comb begin
    priority if (red >= green && red >= blue) begin
      sector = SEC_RED;
    end else if (green >= blue) begin
      sector = SEC_GREEN;
    end else begin
      sector = SEC_BLUE;
    end
  end

  always_comb begin
    unique case (sector)
      SEC_RED: begin
        mx   = red;
        diff = {1'b0, green} - {1'b0, blue};
      end
      SEC_GREEN: begin
        mx   = green;
        diff = {1'b0, blue} - {1'b0, red};
      end
      SEC_BLUE: begin
        mx   = blue;
        diff = {1'b0, red} - {1'b0, green};
      end
      default: begin
        mx   = red;
        diff = '0;
      end
    endcase
  end

  assign lo       = (red < green) ? red : green;
  assign mn       = (lo < blue) ? lo : blue;
  assign abs_full = diff[RGB_W] ? (~diff + 1'b1) : diff;

  always_comb begin
    data_nxt.side.brightness = mx;
    data_nxt.side.delta      = mx - mn;
    data_nxt.side.sector     = sector;
    data_nxt.side.neg        = diff[RGB_W];
    data_nxt.abs_num         = abs_full[RGB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/rhsv_div_pipe.sv =====
module rhsv_div_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  rhsv_pkg::front_t  in_data,
  output logic              out_valid,
  output rhsv_pkg::quot_t   out_quot
);
  import rhsv_pkg::*;

  logic [HDIV_W-1:0] hue_dvd;
  div_stage_t        load_nxt;
  div_stage_t        stg_r [DIV_STAGES+1];
  logic              vld_r [DIV_STAGES+1];

  // hue dividend 3840*|num|; its top bits start out below delta
  assign hue_dvd = HDIV_W'(in_data.abs_num) * HDIV_W'(HUE_SIXTY);

  always_comb begin
    load_nxt.side        = in_data.side;
    // delta << 15: top part is delta >> 1, below brightness
    load_nxt.sat.rem     = {1'b0, in_data.side.delta[RGB_W-1:1]};
    load_nxt.sat.dq      = {in_data.side.delta[0], {(DQ_W-1){1'b0}}};
    load_nxt.sat.divisor = in_data.side.brightness;
    load_nxt.hue.rem     = RGB_W'(hue_dvd[HDIV_W-1:DQ_W]);
    load_nxt.hue.dq      = hue_dvd[DQ_W-1:0];
    load_nxt.hue.divisor = in_data.side.delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= load_nxt;
    end
  end

  // one quotient bit of each divider per stage
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k].side <= stg_r[k-1].side;
        stg_r[k].sat  <= div_step(stg_r[k-1].sat);
        stg_r[k].hue  <= div_step(stg_r[k-1].hue);
      end
    end
  end

  assign out_valid            = vld_r[DIV_STAGES];
  assign out_quot.side        = stg_r[DIV_STAGES].side;
  assign out_quot.sat_q       = stg_r[DIV_STAGES].sat.dq;
  assign out_quot.hue_q       = stg_r[DIV_STAGES].hue.dq;
  assign out_quot.hue_inexact = (stg_r[DIV_STAGES].hue.rem != '0);

endmodule

// ===== sv/rhsv_back.sv =====
module rhsv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  rhsv_pkg::quot_t  in_quot,
  output logic             valid_r,
  output rhsv_pkg::hsv_t   data_r
);
  import rhsv_pkg::*;

  logic [HUE_W+1:0] base;
  logic [HUE_W+1:0] mag;
  logic [HUE_W+1:0] hue_s;
  logic [HUE_W+1:0] hue_w;
  logic             grey;
  hsv_t             data_nxt;

  assign grey = (in_quot.side.delta == '0);
  assign base = (HUE_W+2)'(sector_base(in_quot.side.sector));
  // floor toward minus infinity: round magnitude up when negative and inexact
  assign mag  = (HUE_W+2)'(in_quot.hue_q)
              + (HUE_W+2)'(in_quot.side.neg & in_quot.hue_inexact);
  assign hue_s = in_quot.side.neg ? (base - mag) : (base + mag);
  assign hue_w = hue_s[HUE_W+1] ? (hue_s + (HUE_W+2)'(HUE_FULL)) : hue_s;

  always_comb begin
    data_nxt.brightness = in_quot.side.brightness;
    data_nxt.saturation = grey ? '0 : in_quot.sat_q;
    data_nxt.hue        = grey ? '0 : hue_w[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/rgb_to_hsv_converter_unit.sv =====
// Channel   Dir  Payload                                   Handshake
// in_pix    in   red[7:0] green[7:0] blue[7:0]             valid/ready
// out_hsv   out  hue[14:0] saturation[15:0] brightness[7:0] valid/ready
//
// One pixel per clock sustained while out_hsv.ready stays high.
// The pipe is the max/min stage, the divider load stage, the two 16-step restoring
// dividers (one quotient bit per stage) working side by side, and the hue fix-up stage.
// rst_n (sync, active low) clears all valid bits; payload registers are not reset.
// A one-word skid buffer sits at the output: on a stall the pipe freezes in the next
// cycle, so in_pix.ready is a flop and nothing is dropped or repeated.
module rgb_to_hsv_converter_unit (
  input  logic       clk,
  input  logic       rst_n,
  rhsv_pix_if.sink   in_pix,
  rhsv_hsv_if.source out_hsv
);
  import rhsv_pkg::*;

  logic   en;
  logic   front_vld;
  front_t front_data;
  logic   div_vld;
  quot_t  div_quot;
  logic   back_vld;
  hsv_t   back_data;

  // skid buffer
  logic   skid_full_r;
  logic   skid_full_nxt;
  hsv_t   skid_r;
  hsv_t   out_word;

  // whole pipe advances whenever the skid word is empty
  assign en           = !skid_full_r;
  assign in_pix.ready = en;

  // stage 1: max / min / sector / |num|
  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_pix.valid),
    .red      (in_pix.red),
    .green    (in_pix.green),
    .blue     (in_pix.blue),
    .valid_r  (front_vld),
    .data_r   (front_data)
  );

  // stages 2..18: divider load + 16 quotient-bit steps for S and H
  rhsv_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_vld),
    .in_data   (front_data),
    .out_valid (div_vld),
    .out_quot  (div_quot)
  );

  // stage 19: floor fix-up, sector base, wrap, grey override
  rhsv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (div_vld),
    .in_quot  (div_quot),
    .valid_r  (back_vld),
    .data_r   (back_data)
  );

  // capture the last-stage word when it is not taken; release when taken
  always_comb begin
    if (skid_full_r) begin
      skid_full_nxt = !out_hsv.ready;
    end else begin
      skid_full_nxt = back_vld && !out_hsv.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= back_data;
    end
  end

  // skid word is older than the last-stage word, so it goes first
  assign out_word           = skid_full_r ? skid_r : back_data;
  assign out_hsv.valid      = skid_full_r | back_vld;
  assign out_hsv.hue        = out_word.hue;
  assign out_hsv.saturation = out_word.saturation;
  assign out_hsv.brightness = out_word.brightness;

endmodule
